// File: rtl/core/seven_segment_scan_display_top_defines.svh
// ----------------------------------------------------------------------------
// seven_segment_scan_display_top_defines.svh
// Assertion macros shared by the checker.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_SCAN_DISPLAY_TOP_DEFINES_SVH
`define SEVEN_SEGMENT_SCAN_DISPLAY_TOP_DEFINES_SVH

// same-cycle implication
`define SSD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Types, register indexes and lookup tables of the scan display driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

	localparam int VOLT_W  = 16;
	localparam int SCALE_W = 10;
	localparam int CFG_W   = 10;
	localparam int POS_W   = 3;
	localparam int STORE_N = 6;

	localparam logic [1:0] REG_SCALE_FIRST    = 2'd0;
	localparam logic [1:0] REG_SCALE_SECOND   = 2'd1;
	localparam logic [1:0] REG_REFRESH_PERIOD = 2'd2;

	localparam logic [CFG_W-1:0] RST_SCALE_FIRST    = 10'd133;
	localparam logic [CFG_W-1:0] RST_SCALE_SECOND   = 10'd200;
	localparam logic [CFG_W-1:0] RST_REFRESH_PERIOD = 10'd200;

	localparam logic [9:0] SAT_MAX = 10'd999;
	localparam logic [7:0] DP_MASK = 8'h10;

	typedef struct packed {
		logic [3:0] hund;
		logic [3:0] tens;
		logic [3:0] ones;
	} digits_t;

	typedef struct packed {
		logic             resample;
		logic [POS_W-1:0] pos;
	} ctrl_t;

	function automatic logic [7:0] seg_of(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0:    s = 8'hEE;
			4'd1:    s = 8'h0C;
			4'd2:    s = 8'hCB;
			4'd3:    s = 8'h8F;
			4'd4:    s = 8'h2D;
			4'd5:    s = 8'hA7;
			4'd6:    s = 8'hE7;
			4'd7:    s = 8'h8C;
			4'd8:    s = 8'hEF;
			4'd9:    s = 8'hAF;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

	function automatic logic [2:0] sel_of(input logic [POS_W-1:0] p);
		logic [2:0] s;
		case (p)
			3'd0:    s = 3'd0;
			3'd1:    s = 3'd1;
			3'd2:    s = 3'd2;
			3'd3:    s = 3'd4;
			3'd4:    s = 3'd5;
			3'd5:    s = 3'd6;
			3'd6:    s = 3'd3;
			default: s = 3'd7;
		endcase
		return s;
	endfunction

endpackage

// File: rtl/core/ssd_lane.sv
// ----------------------------------------------------------------------------
// ssd_lane
// One voltage lane: registered scale multiply, then saturate and split into
// hundreds, tens and ones by reciprocal multiplication.
// ----------------------------------------------------------------------------
module ssd_lane
	import ssd_pkg::*;
(
	input  logic               clk,
	input  logic               load,
	input  logic [VOLT_W-1:0]  voltage,
	input  logic [SCALE_W-1:0] scale,
	output digits_t            digits
);

	logic [VOLT_W+SCALE_W-1:0] prod_s1;
	logic [13:0]               shifted;
	logic [9:0]                sat;
	logic [15:0]               h_mul;
	logic [3:0]                hund;
	logic [9:0]                h100;
	logic [9:0]                rem10;
	logic [6:0]                rem;
	logic [14:0]               t_mul;
	logic [3:0]                tens;
	logic [6:0]                t10;
	logic [6:0]                ones7;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= (VOLT_W+SCALE_W)'(voltage) * (VOLT_W+SCALE_W)'(scale);
		end
	end

	always_comb begin
		shifted = prod_s1[VOLT_W+SCALE_W-1:12];
		sat     = (shifted > 14'(SAT_MAX)) ? SAT_MAX : shifted[9:0];
		// v/100 == (v*41)>>12 for v < 1000
		h_mul   = 16'(sat) * 16'd41;
		hund    = h_mul[15:12];
		h100    = 10'(hund) * 10'd100;
		rem10   = sat - h100;
		rem     = rem10[6:0];
		// r/10 == (r*205)>>11 for r < 100
		t_mul   = 15'(rem) * 15'd205;
		tens    = t_mul[14:11];
		t10     = 7'(tens) * 7'd10;
		ones7   = rem - t10;
		digits.hund = hund;
		digits.tens = tens;
		digits.ones = ones7[3:0];
	end

endmodule

// File: rtl/core/ssd_merge.sv
// ----------------------------------------------------------------------------
// ssd_merge
// Merges both lanes into the digit store and builds the output word for the
// current scan position.
// ----------------------------------------------------------------------------
module ssd_merge
	import ssd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  ctrl_t            ctrl,
	input  digits_t          dig_first,
	input  digits_t          dig_second,
	output logic [7:0]       segments,
	output logic [2:0]       select_code,
	output logic [POS_W-1:0] position
);

	logic [3:0] store_q [STORE_N];
	logic [3:0] fresh   [STORE_N];
	logic [3:0] cur     [STORE_N];
	logic [3:0] digit;
	logic [7:0] seg_c;
	logic [7:0] seg_s2;
	logic [2:0] sel_s2;
	logic [POS_W-1:0] pos_s2;

	always_comb begin
		fresh[0] = dig_first.hund;
		fresh[1] = dig_first.tens;
		fresh[2] = dig_first.ones;
		fresh[3] = dig_second.hund;
		fresh[4] = dig_second.tens;
		fresh[5] = dig_second.ones;
		for (int i = 0; i < STORE_N; i++) begin
			cur[i] = ctrl.resample ? fresh[i] : store_q[i];
		end
		digit = 4'd0;
		seg_c = 8'h00;
		case (ctrl.pos)
			3'd0: digit = cur[0];
			3'd1: digit = cur[1];
			3'd2: digit = cur[2];
			3'd3: digit = cur[3];
			3'd4: digit = cur[4];
			3'd5: digit = cur[5];
			default: digit = 4'd0;
		endcase
		if (ctrl.pos < 3'(STORE_N)) begin
			seg_c = seg_of(digit);
			if (ctrl.pos == 3'd1 || ctrl.pos == 3'd3) begin
				seg_c = seg_c | DP_MASK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_N; i++) begin
				store_q[i] <= 4'd0;
			end
		end else if (load && ctrl.resample) begin
			for (int i = 0; i < STORE_N; i++) begin
				store_q[i] <= fresh[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			seg_s2 <= seg_c;
			sel_s2 <= sel_of(ctrl.pos);
			pos_s2 <= ctrl.pos;
		end
	end

	assign segments    = seg_s2;
	assign select_code = sel_s2;
	assign position    = pos_s2;

endmodule

// File: rtl/core/seven_segment_scan_display_top.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_display_top
// Path: the lane multiply register, then the split into digits and the merge output register.
// Throughput: one word per cycle while m_tready is high; the output register lets a new word in
// while a result waits. The pipeline has two stages: lane multiply and merge output.
// Reset: async, clears refresh counter, scan position, digit store and valid
// flags; scale and period registers return to their defaults.
// ----------------------------------------------------------------------------
module seven_segment_scan_display_top
	import ssd_pkg::*;
#(
	parameter int DIGITS = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [31:0]        s_tdata,   // voltage_first, voltage_second
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [15:0]        m_tdata,   // segments, select_code, position, pad
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(DIGITS - 1);

	logic [CFG_W-1:0] scale_first_q;
	logic [CFG_W-1:0] scale_second_q;
	logic [CFG_W-1:0] period_q;
	logic [9:0]       refresh_q;
	logic [POS_W-1:0] pos_q;
	logic             v1_q;
	logic             v2_q;
	ctrl_t            ctrl_s1;
	logic             en2;
	logic             accept;
	logic             load2;
	digits_t          dig_first;
	digits_t          dig_second;
	logic [7:0]       segments;
	logic [2:0]       select_code;
	logic [POS_W-1:0] position;

	assign en2      = !v2_q || m_tready;
	assign s_tready = !v1_q || en2;
	assign accept   = s_tvalid && s_tready;
	assign load2    = v1_q && en2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_first_q  <= RST_SCALE_FIRST;
			scale_second_q <= RST_SCALE_SECOND;
			period_q       <= RST_REFRESH_PERIOD;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_SCALE_FIRST:    scale_first_q  <= cfg_data;
				REG_SCALE_SECOND:   scale_second_q <= cfg_data;
				REG_REFRESH_PERIOD: period_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_q <= 10'd0;
			pos_q     <= '0;
			v1_q      <= 1'b0;
			v2_q      <= 1'b0;
		end else begin
			if (accept) begin
				if (refresh_q == 10'd0) begin
					// zero period acts as one
					refresh_q <= (period_q == 10'd0) ? 10'd0 : period_q - 10'd1;
				end else begin
					refresh_q <= refresh_q - 10'd1;
				end
				pos_q <= (pos_q >= LAST_POS) ? '0 : pos_q + POS_W'(1);
			end
			if (s_tready) begin
				v1_q <= accept;
			end
			if (en2) begin
				v2_q <= v1_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctrl_s1.resample <= (refresh_q == 10'd0);
			ctrl_s1.pos      <= pos_q;
		end
	end

	ssd_lane u_lane_first (
		.clk     (clk),
		.load    (accept),
		.voltage (s_tdata[15:0]),
		.scale   (scale_first_q),
		.digits  (dig_first)
	);

	ssd_lane u_lane_second (
		.clk     (clk),
		.load    (accept),
		.voltage (s_tdata[31:16]),
		.scale   (scale_second_q),
		.digits  (dig_second)
	);

	ssd_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load2),
		.ctrl        (ctrl_s1),
		.dig_first   (dig_first),
		.dig_second  (dig_second),
		.segments    (segments),
		.select_code (select_code),
		.position    (position)
	);

	assign m_tvalid = v2_q;
	assign m_tdata  = {2'b00, position, select_code, segments};

endmodule

// File: rtl/core/ssd_checker.sv
// ----------------------------------------------------------------------------
// ssd_checker
// Port-level checks of the scan display driver, bound to the top level.
// ----------------------------------------------------------------------------
`include "seven_segment_scan_display_top_defines.svh"

module ssd_checker
	import ssd_pkg::*;
#(
	parameter int DIGITS = 6
) (
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [15:0]      m_tdata
);

	`SSD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")
	`SSD_ASSERT_NOW(a_pos_range, m_tvalid, m_tdata[13:11] <= 3'(DIGITS - 1), "position past digit count")
	`SSD_ASSERT_NOW(a_sel_map, m_tvalid, m_tdata[10:8] == sel_of(m_tdata[13:11]), "select code does not match position")
	`SSD_ASSERT_NOW(a_dp, m_tvalid && (m_tdata[13:11] == 3'd1 || m_tdata[13:11] == 3'd3), m_tdata[4], "decimal point missing")

endmodule

bind seven_segment_scan_display_top ssd_checker #(.DIGITS(DIGITS)) u_ssd_checker (.*);
